FILE: sv/twc_pkg.sv
package twc_pkg;

    localparam int unsigned CpWidth = 21;

    localparam logic [CpWidth-1:0] CH_SPACE   = 21'd32;
    localparam logic [CpWidth-1:0] CH_NEWLINE = 21'd10;
    localparam logic [CpWidth-1:0] CH_CR      = 21'd13;
    localparam logic [CpWidth-1:0] CH_DQUOTE  = 21'd34;
    localparam logic [CpWidth-1:0] CH_SQUOTE  = 21'd39;
    localparam logic [CpWidth-1:0] CH_HYPHEN  = 21'd45;

    typedef enum logic [1:0] {
        CLS_OTHER   = 2'd0,
        CLS_SPACE   = 2'd1,
        CLS_NEWLINE = 2'd2,
        CLS_CR      = 2'd3
    } t_class;

    // work handed from the front to the back
    typedef struct packed {
        logic [CpWidth-1:0] point;
        logic               extra_nl;
        logic               emit;
    } t_job;

    // fixed typographic substitution table
    function automatic logic [CpWidth-1:0] map_point(input logic [CpWidth-1:0] cp);
        logic [CpWidth-1:0] res;
        res = cp;
        case (cp)
            21'd8220, 21'd8221:                       res = CH_DQUOTE;
            21'd8216, 21'd8217:                       res = CH_SQUOTE;
            21'd8291, 21'd8229, 21'd160:              res = CH_SPACE;
            21'd8226, 21'd9679, 21'd8210, 21'd8211,
            21'd8212, 21'd8213, 21'd8275, 21'd11834,
            21'd11835:                                res = CH_HYPHEN;
            default:                                  res = cp;
        endcase
        return res;
    endfunction

    function automatic t_class classify(input logic [CpWidth-1:0] cp);
        t_class res;
        if (cp == CH_SPACE) begin
            res = CLS_SPACE;
        end else if (cp == CH_NEWLINE) begin
            res = CLS_NEWLINE;
        end else if (cp == CH_CR) begin
            res = CLS_CR;
        end else begin
            res = CLS_OTHER;
        end
        return res;
    endfunction

endpackage

FILE: sv/twc_front.sv
module twc_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [twc_pkg::CpWidth-1:0]      i_code_point,
    input  logic                             i_first_of_text,
    input  logic                             i_q_full,
    output logic                             o_q_push,
    output twc_pkg::t_job                    o_q_job
);

    twc_pkg::t_class r_last, n_last;
    twc_pkg::t_class r_before, n_before;

    logic                        accept;
    logic [twc_pkg::CpWidth-1:0] mapped;
    twc_pkg::t_class             cls;
    twc_pkg::t_class             lc0, blc0, lc1, blc1;
    logic                        extra;
    logic                        emit;

    assign accept  = i_valid && !i_q_full;
    assign o_stall = i_q_full;

    always_comb begin
        lc0    = i_first_of_text ? twc_pkg::CLS_OTHER : r_last;
        blc0   = i_first_of_text ? twc_pkg::CLS_OTHER : r_before;
        mapped = twc_pkg::map_point(i_code_point);
        cls    = twc_pkg::classify(mapped);
        extra  = (lc0 == twc_pkg::CLS_CR) && (cls != twc_pkg::CLS_NEWLINE);
        // the inserted newline advances history first
        lc1    = extra ? twc_pkg::CLS_NEWLINE : lc0;
        blc1   = extra ? lc0 : blc0;
        case (cls)
            twc_pkg::CLS_SPACE:   emit = (lc1 != twc_pkg::CLS_SPACE);
            twc_pkg::CLS_NEWLINE: emit = (blc1 != twc_pkg::CLS_NEWLINE);
            default:              emit = 1'b1;
        endcase
        n_last   = r_last;
        n_before = r_before;
        if (accept) begin
            n_before = lc1;
            n_last   = cls;
        end
        o_q_job.point    = mapped;
        o_q_job.extra_nl = extra;
        o_q_job.emit     = emit;
        // a dropped point with no inserted newline yields nothing
        o_q_push = accept && (extra || emit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= twc_pkg::CLS_OTHER;
            r_before <= twc_pkg::CLS_OTHER;
        end else begin
            r_last   <= n_last;
            r_before <= n_before;
        end
    end

endmodule

FILE: sv/twc_queue.sv
module twc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  twc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_not_empty,
    output twc_pkg::t_job o_head
);

    twc_pkg::t_job r_mem [2];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_count, n_count;
    logic          do_push, do_pop;

    assign o_full      = (r_count == 2'd2);
    assign o_not_empty = (r_count != 2'd0);
    assign o_head      = r_mem[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: sv/twc_back.sv
module twc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_not_empty,
    input  twc_pkg::t_job               i_q_head,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [twc_pkg::CpWidth-1:0] o_out_point,
    output logic                        o_last_of_run
);

    logic                        r_valid, n_valid;
    logic                        r_phase, n_phase;
    logic [twc_pkg::CpWidth-1:0] r_point, n_point;
    logic                        r_last, n_last;
    logic                        load;
    logic                        nl_step;

    assign load          = !r_valid || !i_stall;
    assign o_valid       = r_valid;
    assign o_out_point   = r_point;
    assign o_last_of_run = r_last;

    always_comb begin
        n_valid = r_valid;
        n_phase = r_phase;
        n_point = r_point;
        n_last  = r_last;
        o_q_pop = 1'b0;
        nl_step = i_q_head.extra_nl && !r_phase;
        if (load) begin
            n_valid = i_q_not_empty;
            if (i_q_not_empty) begin
                if (nl_step) begin
                    n_point = twc_pkg::CH_NEWLINE;
                    n_last  = !i_q_head.emit;
                    // keep the entry when the point itself still follows
                    n_phase = i_q_head.emit;
                    o_q_pop = !i_q_head.emit;
                end else begin
                    n_point = i_q_head.point;
                    n_last  = 1'b1;
                    n_phase = 1'b0;
                    o_q_pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_point <= n_point;
        r_last  <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

endmodule

FILE: sv/text_whitespace_cleaner_unit.sv
// latency: a request is pushed into the queue when it is accepted, and its first result
// then goes from the queue into the output register
// throughput: one request per cycle while the queue is not full; a request with an
// inserted newline and a kept point yields the newline, then the point, and can stall the
// input when requests run back to back; reset: synchronous, active low; clears history to
// other, empties the queue and drops any pending result
module text_whitespace_cleaner_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [twc_pkg::CpWidth-1:0] i_code_point,
    input  logic                        i_first_of_text,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [twc_pkg::CpWidth-1:0] o_out_point,
    output logic                        o_last_of_run
);

    logic          q_full;
    logic          q_push;
    twc_pkg::t_job q_job;
    logic          q_pop;
    logic          q_not_empty;
    twc_pkg::t_job q_head;

    twc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_code_point    (i_code_point),
        .i_first_of_text (i_first_of_text),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_job         (q_job)
    );

    twc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_job       (q_job),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_head      (q_head)
    );

    twc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_q_head      (q_head),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_point   (o_out_point),
        .o_last_of_run (o_last_of_run)
    );

endmodule

FILE: dv/text_whitespace_cleaner_unit_test.sv
`default_nettype none

module text_whitespace_cleaner_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import twc_pkg::*;

    typedef struct {
        logic [CpWidth-1:0] point;
        logic               tail;
    } owed_t;

    // typographic points worth hitting often in the random part
    localparam logic [CpWidth-1:0] TYPO_POINTS [16] = '{
        21'd8220, 21'd8221, 21'd8216, 21'd8217, 21'd8291, 21'd8229, 21'd160, 21'd8226,
        21'd9679, 21'd8210, 21'd8211, 21'd8212, 21'd8213, 21'd8275, 21'd11834, 21'd11835
    };

    // {first_of_text, code_point}
    localparam logic [CpWidth:0] DIRECTED [26] = '{
        {1'b1, 21'd65},
        {1'b0, 21'd0}, {1'b0, 21'h1FFFFF}, {1'b0, 21'd1114111},
        {1'b0, 21'd32}, {1'b0, 21'd32}, {1'b0, 21'd160},
        {1'b0, 21'd10}, {1'b0, 21'd10}, {1'b0, 21'd10},
        {1'b0, 21'd13}, {1'b0, 21'd66},
        {1'b0, 21'd13}, {1'b0, 21'd10},
        {1'b0, 21'd13}, {1'b0, 21'd32},
        {1'b0, 21'd13}, {1'b0, 21'd13},
        {1'b0, 21'd13}, {1'b1, 21'd13},
        {1'b0, 21'd8220},
        {1'b0, 21'd8216}, {1'b0, 21'd8291}, {1'b0, 21'd8226}, {1'b0, 21'd11835},
        {1'b0, 21'd8213}
    };

    class clean_point_ledger;
        t_class last_cls;
        t_class prior_cls;
        owed_t  owed[$];
        int     mismatches;
        int     points_taken;
        int     results_seen;
        int     newlines_inserted;
        int     points_dropped;

        function new();
            last_cls  = CLS_OTHER;
            prior_cls = CLS_OTHER;
        endfunction

        function void push_cls(t_class c);
            prior_cls = last_cls;
            last_cls  = c;
        endfunction

        function void note_point(logic [CpWidth-1:0] cp_in, logic first);
            logic [CpWidth-1:0] cp;
            t_class             cls;
            logic               keep;
            int                 added;
            added = 0;
            points_taken++;
            if (first) begin
                last_cls  = CLS_OTHER;
                prior_cls = CLS_OTHER;
            end
            case (cp_in)
                21'd8220, 21'd8221:                   cp = CH_DQUOTE;
                21'd8216, 21'd8217:                   cp = CH_SQUOTE;
                21'd8291, 21'd8229, 21'd160:          cp = CH_SPACE;
                21'd8226, 21'd9679, 21'd8210, 21'd8211, 21'd8212, 21'd8213,
                21'd8275, 21'd11834, 21'd11835:       cp = CH_HYPHEN;
                default:                              cp = cp_in;
            endcase
            if (cp == CH_SPACE) begin
                cls = CLS_SPACE;
            end else if (cp == CH_NEWLINE) begin
                cls = CLS_NEWLINE;
            end else if (cp == CH_CR) begin
                cls = CLS_CR;
            end else begin
                cls = CLS_OTHER;
            end
            // lone carriage return gets its newline before the point
            if (last_cls == CLS_CR && cls != CLS_NEWLINE) begin
                owed.push_back('{CH_NEWLINE, 1'b0});
                added++;
                newlines_inserted++;
                push_cls(CLS_NEWLINE);
            end
            if (cls == CLS_SPACE) begin
                keep = (last_cls != CLS_SPACE);
            end else if (cls == CLS_NEWLINE) begin
                keep = (prior_cls != CLS_NEWLINE);
            end else begin
                keep = 1'b1;
            end
            if (keep) begin
                owed.push_back('{cp, 1'b0});
                added++;
            end else begin
                points_dropped++;
            end
            push_cls(cls);
            if (added > 0) begin
                owed[owed.size()-1].tail = 1'b1;
            end
        endfunction

        function void take_result(logic [CpWidth-1:0] pt, logic tail);
            owed_t exp_r;
            results_seen++;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual point %0d last %0b",
                         $time, pt, tail);
                mismatches++;
                return;
            end
            exp_r = owed.pop_front();
            if (pt !== exp_r.point) begin
                $display("%0t: out_point mismatch, expected %0d, actual %0d",
                         $time, exp_r.point, pt);
                mismatches++;
            end
            if (tail !== exp_r.tail) begin
                $display("%0t: last_of_run mismatch, expected %0b, actual %0b",
                         $time, exp_r.tail, tail);
                mismatches++;
            end
        endfunction

        function void close_out();
            foreach (owed[k]) begin
                $display("%0t: missing result, expected point %0d last %0b, actual none",
                         $time, owed[k].point, owed[k].tail);
                mismatches++;
            end
            owed.delete();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [CpWidth-1:0]  i_code_point = '0;
    logic                i_first_of_text = 1'b0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [CpWidth-1:0]  o_out_point;
    logic                o_last_of_run;

    clean_point_ledger ledger = new();
    int tx_idle_pct = 34;
    int rx_idle_pct = 34;

    text_whitespace_cleaner_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_code_point    (i_code_point),
        .i_first_of_text (i_first_of_text),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_point     (o_out_point),
        .o_last_of_run   (o_last_of_run)
    );

    always #2 i_clk = ~i_clk;

    task automatic offer_point(input logic [CpWidth-1:0] cp, input logic first);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_code_point    <= cp;
        i_first_of_text <= first;
        do @(posedge i_clk); while (o_stall);
        ledger.note_point(cp, first);
    endtask

    function automatic logic [CpWidth-1:0] pick_point();
        int r;
        r = $urandom_range(99);
        if (r < 14) begin
            return CH_SPACE;
        end else if (r < 24) begin
            return CH_NEWLINE;
        end else if (r < 34) begin
            return CH_CR;
        end else if (r < 52) begin
            return TYPO_POINTS[$urandom_range(15)];
        end else if (r < 80) begin
            return CpWidth'($urandom_range(33, 126));
        end
        return CpWidth'($urandom);
    endfunction

    // result side, with one long hold-off so the block backs up into the sender
    initial begin
        int  hold_left;
        bit  held_once;
        hold_left = 0;
        held_once = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                ledger.take_result(o_out_point, o_last_of_run);
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (!held_once && ledger.results_seen >= 400) begin
                held_once = 1;
                hold_left = 150;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    initial begin
        int   text_left;
        logic first;
        text_left = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) begin
            offer_point(DIRECTED[k][CpWidth-1:0], DIRECTED[k][CpWidth]);
        end

        for (int k = 0; k < 1900; k++) begin
            if (k == 900) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (k == 1200) begin
                tx_idle_pct = 34;
                rx_idle_pct = 34;
            end
            // texts of random length, with the odd early restart
            if (text_left == 0 || $urandom_range(99) == 0) begin
                first     = 1'b1;
                text_left = $urandom_range(1, 60);
            end else begin
                first = 1'b0;
            end
            text_left--;
            offer_point(pick_point(), first);
        end
        i_valid <= 1'b0;

        while (ledger.owed.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        ledger.close_out();

        $display("covered %0d points, %0d results, %0d inserted newlines, %0d dropped points",
                 ledger.points_taken, ledger.results_seen, ledger.newlines_inserted,
                 ledger.points_dropped);
        $display("random idling on both sides, a stall-free stretch and one long output hold-off");
        if (ledger.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

FILE: text_whitespace_cleaner_unit.f
sv/twc_pkg.sv
sv/twc_front.sv
sv/twc_queue.sv
sv/twc_back.sv
sv/text_whitespace_cleaner_unit.sv
dv/text_whitespace_cleaner_unit_test.sv
